[hdl/srtc_pkg.sv]
// Shared types, pin and command codes, and BCD helpers for the serial RTC pin port.
`timescale 1ns / 1ps
package srtc_pkg;

	// Bit positions inside the pin byte.
	localparam int unsigned PIN_DATA = 0;
	localparam int unsigned PIN_CLK  = 1;
	localparam int unsigned PIN_SEL  = 2;
	localparam int unsigned PIN_DIR  = 4;

	localparam int unsigned CNT_W = 7;

	// Command kinds, taken from bits 6:4 of the command byte.
	localparam logic [2:0] CMD_STATUS_ONE = 3'd0;
	localparam logic [2:0] CMD_DATE_TIME  = 3'd2;
	localparam logic [2:0] CMD_STATUS_TWO = 3'd4;
	localparam logic [2:0] CMD_TIME_ONLY  = 3'd6;

	// Status one bit that selects 24-hour mode.
	localparam int unsigned STAT_24H = 1;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [6:0] year_two_digit;
		logic [3:0] month;
		logic [4:0] day_of_month;
		logic [2:0] weekday;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} srtc_time_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [CNT_W-1:0] bit_counter;
		logic             mode_24h;
	} srtc_rd_ctl_t;

	// Binary to packed BCD; the divide by ten is a reciprocal multiply.
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [3:0]  ones;
		prod = 15'(v) * 15'd205;
		tens = prod[14:11];
		ones = 4'(v - 7'(7'(tens) * 7'd10));
		return {tens, ones};
	endfunction

	// Hour reduced to twelve-hour form; no AM/PM flag is kept.
	function automatic logic [4:0] hour_mod12(input logic [4:0] h);
		logic [4:0] r;
		if (h >= 5'd24) begin
			r = h - 5'd24;
		end else if (h >= 5'd12) begin
			r = h - 5'd12;
		end else begin
			r = h;
		end
		return r;
	endfunction

	// Remainder by three for a four-bit value.
	function automatic logic [1:0] mod3(input logic [3:0] x);
		logic [7:0] prod;
		logic [2:0] q;
		prod = 8'(x) * 8'd11;
		q = prod[7:5];
		return 2'(x - 4'(4'(q) * 4'd3));
	endfunction

endpackage

[hdl/srtc_read_mux.sv]
// Selects the serial read bit from the status registers or the BCD time bytes.
`timescale 1ns / 1ps
module srtc_read_mux (
	input  srtc_pkg::srtc_rd_ctl_t ctl,
	input  logic [7:0]             status_one,
	input  logic [7:0]             status_two,
	input  srtc_pkg::srtc_time_t   tm,
	output logic                   rd_bit
);
	import srtc_pkg::*;

	logic [3:0] byte_no;
	logic [7:0] hour_b;
	logic [7:0] sel_byte;
	logic [1:0] wrap_idx;

	assign byte_no  = ctl.bit_counter[CNT_W-1:3];
	assign wrap_idx = mod3(byte_no - 4'd1);
	assign hour_b   = ctl.mode_24h ? to_bcd(7'(tm.hour)) : to_bcd(7'(hour_mod12(tm.hour)));

	always_comb begin
		sel_byte = 8'h00;
		case (ctl.kind)
			CMD_STATUS_ONE: sel_byte = status_one;
			CMD_STATUS_TWO: sel_byte = status_two;
			CMD_DATE_TIME: begin
				case (byte_no)
					4'd1:    sel_byte = to_bcd(tm.year_two_digit);
					4'd2:    sel_byte = to_bcd(7'(tm.month));
					4'd3:    sel_byte = to_bcd(7'(tm.day_of_month));
					4'd4:    sel_byte = to_bcd(7'(tm.weekday));
					4'd5:    sel_byte = hour_b;
					4'd6:    sel_byte = to_bcd(7'(tm.minute));
					4'd7:    sel_byte = to_bcd(7'(tm.second));
					default: sel_byte = 8'h00;
				endcase
			end
			CMD_TIME_ONLY: begin
				case (wrap_idx)
					2'd0:    sel_byte = hour_b;
					2'd1:    sel_byte = to_bcd(7'(tm.minute));
					default: sel_byte = to_bcd(7'(tm.second));
				endcase
			end
			default: sel_byte = 8'h00;
		endcase
	end

	assign rd_bit = sel_byte[ctl.bit_counter[2:0]];

endmodule

[hdl/serial_rtc_pin_interface.sv]
// Top level of the bit-banged three-wire serial RTC pin port.
// A request accepted into the input register is then applied to the port state,
// and its result loaded into the result register, as the pipeline advances.
// Throughput: one request per cycle while no result is held at the output.
// Results can sit in the output register under stall while a new request waits
// in the input register. Reset (arst_n low, asynchronous) clears the pin latch,
// bit counter, command byte, both status registers and the valid flags.
`timescale 1ns / 1ps
module serial_rtc_pin_interface (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       operation,
	input  logic [7:0] pin_byte,
	input  logic [6:0] year_two_digit,
	input  logic [3:0] month,
	input  logic [4:0] day_of_month,
	input  logic [2:0] weekday,
	input  logic [4:0] hour,
	input  logic [5:0] minute,
	input  logic [5:0] second,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] pin_value
);
	import srtc_pkg::*;

	// Input register: one request waiting to be applied to the port state.
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] pin_s1;
	srtc_time_t tm_s1;

	// Port state.
	logic [7:0]       pin_latch_q;
	logic [CNT_W-1:0] bit_counter_q;
	logic [7:0]       command_q;
	logic [7:0]       status_one_q;
	logic [7:0]       status_two_q;

	// Result register.
	logic       out_valid_q;
	logic [7:0] pin_value_q;

	// Next-state values for the request in the input register.
	logic [7:0]       pin_nxt;
	logic [CNT_W-1:0] cnt_nxt;
	logic [7:0]       cmd_nxt;
	logic [7:0]       st1_nxt;
	logic [7:0]       st2_nxt;
	logic [7:0]       result;
	logic [7:0]       wmask;
	logic             fall_edge;
	logic             rd_bit;
	logic             advance;
	srtc_rd_ctl_t     rd_ctl;

	// The pipeline moves unless a finished result is held by the receiver.
	assign advance  = !(out_valid_q && out_stall);
	// An empty input register takes a request even while the output is held.
	assign in_stall = valid_s1 && !advance;

	assign rd_ctl.kind        = command_q[6:4];
	assign rd_ctl.bit_counter = bit_counter_q;
	assign rd_ctl.mode_24h    = status_one_q[STAT_24H];

	srtc_read_mux u_read_mux (
		.ctl        (rd_ctl),
		.status_one (status_one_q),
		.status_two (status_two_q),
		.tm         (tm_s1),
		.rd_bit     (rd_bit)
	);

	assign fall_edge = pin_latch_q[PIN_CLK] && !pin_s1[PIN_CLK];
	assign wmask     = 8'(1) << bit_counter_q[2:0];

	// One serial step. With select high, a falling clock edge shifts one bit:
	// the first eight build the command, later ones write a status register
	// when the host drives data, or return a read bit on data bit 0 otherwise.
	// Without an edge, a host read keeps the last data bit. Select low clears
	// the bit counter and the command.
	always_comb begin
		pin_nxt = pin_s1;
		cnt_nxt = bit_counter_q;
		cmd_nxt = command_q;
		st1_nxt = status_one_q;
		st2_nxt = status_two_q;
		if (pin_s1[PIN_SEL]) begin
			if (fall_edge) begin
				if (bit_counter_q[CNT_W-1:3] == '0) begin
					cmd_nxt = command_q | (8'(pin_s1[PIN_DATA]) << bit_counter_q[2:0]);
				end else if (pin_s1[PIN_DIR]) begin
					// Writes to anything but the two status registers are dropped.
					if (command_q[6:4] == CMD_STATUS_ONE) begin
						st1_nxt = pin_s1[PIN_DATA] ? (status_one_q | wmask)
							: (status_one_q & ~wmask);
					end else if (command_q[6:4] == CMD_STATUS_TWO) begin
						st2_nxt = pin_s1[PIN_DATA] ? (status_two_q | wmask)
							: (status_two_q & ~wmask);
					end
				end else begin
					pin_nxt[PIN_DATA] = rd_bit;
				end
				// The counter holds at its top value.
				if (bit_counter_q != CNT_MAX) begin
					cnt_nxt = bit_counter_q + 1'b1;
				end
			end else if (!pin_s1[PIN_DIR]) begin
				pin_nxt[PIN_DATA] = pin_latch_q[PIN_DATA];
			end
		end else begin
			cnt_nxt = '0;
			cmd_nxt = '0;
		end
		// A read request returns the latch and leaves the state alone.
		result = op_s1 ? pin_nxt : pin_latch_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance || !valid_s1) begin
			op_s1                <= operation;
			pin_s1               <= pin_byte;
			tm_s1.year_two_digit <= year_two_digit;
			tm_s1.month          <= month;
			tm_s1.day_of_month   <= day_of_month;
			tm_s1.weekday        <= weekday;
			tm_s1.hour           <= hour;
			tm_s1.minute         <= minute;
			tm_s1.second         <= second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_latch_q   <= '0;
			bit_counter_q <= '0;
			command_q     <= '0;
			status_one_q  <= '0;
			status_two_q  <= '0;
			out_valid_q   <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1 && op_s1) begin
				pin_latch_q   <= pin_nxt;
				bit_counter_q <= cnt_nxt;
				command_q     <= cmd_nxt;
				status_one_q  <= st1_nxt;
				status_two_q  <= st2_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			pin_value_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign pin_value = pin_value_q;

endmodule

[hdl/srtc_checker.sv]
// Port-level checker for the serial RTC pin port, bound to the top level.
`timescale 1ns / 1ps
module srtc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] pin_value
);

	// A held result keeps its value and stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pin_value))
		else $error("held result changed or dropped");

	// Requests are only refused while a result is held at the output.
	a_stall_cause: assert property (@(posedge clk)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// No result is offered while reset is applied.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("port active during reset");

	// A fresh result follows a request accepted into the input register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without an accepted request");

endmodule

bind serial_rtc_pin_interface srtc_checker u_srtc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pin_value (pin_value)
);

[tb/serial_rtc_pin_interface_tb.sv]
// Self-checking testbench for the serial RTC pin port: predicts each pin result and checks it.
`timescale 1ns / 1ps
module serial_rtc_pin_interface_tb;
	import srtc_pkg::*;

	// Request operation codes.
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// No new transfer starts once this many requests have been accepted.
	localparam int unsigned REQUEST_TARGET = 900;

	// Cycles the receiver refuses results during the backpressure test.
	localparam int unsigned HOLD_CYCLES = 120;

	// Predicts the pin register that every accepted request leaves behind and
	// checks the block's results against those predictions in order.
	class rtc_pin_scoreboard;
		logic [7:0] pin_state;
		logic [6:0] bit_count;
		logic [7:0] command_byte;
		logic [7:0] status_one;
		logic [7:0] status_two;
		logic [7:0] expected_pins[$];
		int unsigned failures;

		function new();
			pin_state = '0;
			bit_count = '0;
			command_byte = '0;
			status_one = '0;
			status_two = '0;
			failures = 0;
		endfunction

		function logic [7:0] bcd_byte(input int unsigned v);
			return 8'(((v / 10) << 4) | (v % 10));
		endfunction

		function logic [7:0] hour_byte(input logic [4:0] h);
			if (status_one[STAT_24H]) begin
				return bcd_byte(h);
			end
			return bcd_byte(h % 12);
		endfunction

		function void note_request(input logic op, input logic [7:0] pin,
				input srtc_time_t t);
			logic [7:0] data;
			logic [7:0] src;
			logic [2:0] kind;
			logic [3:0] byte_no;
			logic       falling;
			if (op == OP_WRITE) begin
				data = pin;
				if (data[PIN_SEL]) begin
					falling = pin_state[PIN_CLK] && !data[PIN_CLK];
					kind = command_byte[6:4];
					byte_no = bit_count[6:3];
					if (falling) begin
						if (bit_count < 7'd8) begin
							command_byte = command_byte | (8'(data[PIN_DATA]) << bit_count);
						end else if (data[PIN_DIR]) begin
							if (kind == CMD_STATUS_ONE) begin
								status_one[bit_count[2:0]] = data[PIN_DATA];
							end else if (kind == CMD_STATUS_TWO) begin
								status_two[bit_count[2:0]] = data[PIN_DATA];
							end
						end else begin
							// Pick the byte being read out, then its bit.
							src = '0;
							case (kind)
								CMD_STATUS_ONE: src = status_one;
								CMD_STATUS_TWO: src = status_two;
								CMD_DATE_TIME: begin
									case (byte_no)
										4'd1: src = bcd_byte(t.year_two_digit);
										4'd2: src = bcd_byte(t.month);
										4'd3: src = bcd_byte(t.day_of_month);
										4'd4: src = bcd_byte(t.weekday);
										4'd5: src = hour_byte(t.hour);
										4'd6: src = bcd_byte(t.minute);
										4'd7: src = bcd_byte(t.second);
										default: src = '0;
									endcase
								end
								CMD_TIME_ONLY: begin
									case ((int'(byte_no) - 1) % 3)
										0: src = hour_byte(t.hour);
										1: src = bcd_byte(t.minute);
										default: src = bcd_byte(t.second);
									endcase
								end
								default: src = '0;
							endcase
							data[PIN_DATA] = src[bit_count[2:0]];
						end
						if (bit_count != CNT_MAX) begin
							bit_count = bit_count + 7'd1;
						end
					end else if (!data[PIN_DIR]) begin
						data[PIN_DATA] = pin_state[PIN_DATA];
					end
				end else begin
					bit_count = '0;
					command_byte = '0;
				end
				pin_state = data;
			end
			expected_pins.push_back(pin_state);
		endfunction

		function void check_result(input logic [7:0] actual);
			logic [7:0] want;
			if (expected_pins.size() == 0) begin
				$error("pin_value: expected nothing, actual %02h", actual);
				failures++;
			end else begin
				want = expected_pins.pop_front();
				if (want !== actual) begin
					$error("pin_value: expected %02h, actual %02h", want, actual);
					failures++;
				end
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       operation;
	logic [7:0] pin_byte;
	logic [6:0] year_two_digit;
	logic [3:0] month;
	logic [4:0] day_of_month;
	logic [2:0] weekday;
	logic [4:0] hour;
	logic [5:0] minute;
	logic [5:0] second;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] pin_value;

	rtc_pin_scoreboard sb;
	int unsigned requests_sent;
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned phase_no;

	serial_rtc_pin_interface u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.pin_byte(pin_byte),
		.year_two_digit(year_two_digit),
		.month(month),
		.day_of_month(day_of_month),
		.weekday(weekday),
		.hour(hour),
		.minute(minute),
		.second(second),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pin_value(pin_value)
	);

	always #1 clk = ~clk;

	// Time fields are mostly legal calendar values. One request in eight gets
	// arbitrary bits so that every bit of every field toggles and the BCD
	// conversion is exercised beyond the normal ranges.
	function automatic srtc_time_t pick_time();
		srtc_time_t t;
		if ($urandom_range(7) == 0) begin
			t = srtc_time_t'($bits(srtc_time_t)'({$urandom, $urandom}));
		end else begin
			t.year_two_digit = 7'($urandom_range(99));
			t.month = 4'($urandom_range(12, 1));
			t.day_of_month = 5'($urandom_range(31, 1));
			t.weekday = 3'($urandom_range(6));
			t.hour = 5'($urandom_range(23));
			t.minute = 6'($urandom_range(59));
			t.second = 6'($urandom_range(59));
		end
		return t;
	endfunction

	// Builds a pin byte with the given wire levels. The unused bits are random
	// so that the block must ignore them.
	function automatic logic [7:0] pin_with(input logic d, input logic c, input logic s,
			input logic dir);
		logic [7:0] p;
		p = 8'($urandom);
		p[PIN_DATA] = d;
		p[PIN_CLK] = c;
		p[PIN_SEL] = s;
		p[PIN_DIR] = dir;
		return p;
	endfunction

	// Offers one request, with random idle cycles in front of it at the
	// current sender rate, and holds it steady until the block takes it.
	task automatic send_request(input logic op, input logic [7:0] pin, input srtc_time_t t);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pin_byte <= pin;
		year_two_digit <= t.year_two_digit;
		month <= t.month;
		day_of_month <= t.day_of_month;
		weekday <= t.weekday;
		hour <= t.hour;
		minute <= t.minute;
		second <= t.second;
		do begin
			@(posedge clk);
		end while (in_stall);
		sb.note_request(op, pin, t);
		requests_sent++;
	endtask

	// One serial bit: clock high, then clock low, which is the falling edge
	// that moves the bit.
	task automatic clock_bit(input logic d, input logic dir);
		send_request(OP_WRITE, pin_with(d, 1'b1, 1'b1, dir), pick_time());
		send_request(OP_WRITE, pin_with(d, 1'b0, 1'b1, dir), pick_time());
	endtask

	// A complete select window: deselect, command bits LSB first, then data
	// bits in the given direction, then deselect again. A short command count
	// gives a broken command that select clears. Reads of the pin register and
	// writes that hold the clock low are mixed in between data bits.
	task automatic run_transfer(input logic [2:0] kind, input logic dir,
			input int unsigned cmd_bits, input int unsigned data_bits);
		logic [7:0] cmd;
		cmd = {1'($urandom), kind, 4'($urandom)};
		send_request(OP_WRITE, pin_with(1'($urandom), 1'($urandom), 1'b0, 1'($urandom)),
			pick_time());
		for (int unsigned i = 0; i < cmd_bits; i++) begin
			clock_bit(cmd[i], 1'($urandom));
		end
		for (int unsigned i = 0; i < data_bits; i++) begin
			case ($urandom_range(9))
				0: send_request(OP_READ, 8'($urandom), pick_time());
				1: send_request(OP_WRITE, pin_with(1'($urandom), 1'b0, 1'b1, dir), pick_time());
				default: ;
			endcase
			clock_bit(1'($urandom), dir);
		end
		send_request(OP_WRITE, pin_with(1'($urandom), 1'($urandom), 1'b0, 1'($urandom)),
			pick_time());
	endtask

	// Results are taken at the rising edge; out_stall is driven by this bench
	// and is stable there.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(pin_value);
		end
	end

	// Receiver side. Random stalls follow the current rate. When the third
	// phase starts, the receiver refuses results for a long stretch while the
	// sender keeps offering requests, so the pipeline fills and the block has
	// to stall its input.
	initial begin
		int unsigned hold_left;
		bit          hold_done;
		out_stall = 1'b0;
		hold_left = 0;
		hold_done = 0;
		forever begin
			@(negedge clk);
			if (!hold_done && phase_no == 3) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// Hard stop in case the block hangs: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		srtc_time_t  t_low;
		srtc_time_t  t_high;
		int unsigned xfer_no;
		int unsigned r;
		logic [2:0]  kind;
		logic        dir;
		int unsigned cmd_bits;
		int unsigned data_bits;

		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_READ;
		pin_byte = '0;
		year_two_digit = '0;
		month = '0;
		day_of_month = '0;
		weekday = '0;
		hour = '0;
		minute = '0;
		second = '0;
		requests_sent = 0;
		phase_no = 1;
		tx_idle_pct = 36;
		rx_idle_pct = 63;
		xfer_no = 0;

		t_low = '0;
		t_low.month = 4'd1;
		t_low.day_of_month = 5'd1;
		t_high = '1;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed: read after reset, all-zero and all-one pin bytes, a
		// command bit on a falling edge, a read with no edge that keeps the
		// previous data bit, and a drop of select that clears the command.
		send_request(OP_READ, 8'h00, t_low);
		send_request(OP_WRITE, 8'h00, t_low);
		send_request(OP_WRITE, 8'hFF, t_high);
		send_request(OP_WRITE, 8'hFD, t_high);
		send_request(OP_READ, 8'hFF, t_high);
		send_request(OP_WRITE, 8'hEF, t_low);
		send_request(OP_WRITE, 8'hEC, t_high);
		send_request(OP_WRITE, 8'hFB, t_low);
		send_request(OP_WRITE, 8'h00, t_high);

		// Random transfers. The first eight walk through every command kind,
		// the ninth reads the date-time bytes until the counter saturates.
		while (requests_sent < REQUEST_TARGET) begin
			if (requests_sent >= 2 * REQUEST_TARGET / 3 && phase_no != 3) begin
				phase_no = 3;
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (requests_sent >= REQUEST_TARGET / 3 && phase_no == 1) begin
				phase_no = 2;
				tx_idle_pct = 63;
				rx_idle_pct = 36;
			end
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(4, 1)) begin
					send_request(1'($urandom), 8'($urandom), pick_time());
				end
			end
			kind = (xfer_no < 8) ? 3'(xfer_no) : 3'($urandom);
			if (kind == CMD_STATUS_ONE || kind == CMD_STATUS_TWO) begin
				dir = 1'($urandom);
			end else begin
				dir = ($urandom_range(4) == 0);
			end
			cmd_bits = ($urandom_range(9) == 0) ? $urandom_range(7) : 8;
			r = $urandom_range(19);
			if (r == 0) begin
				data_bits = $urandom_range(135, 100);
			end else if (r < 4) begin
				data_bits = $urandom_range(64, 25);
			end else begin
				data_bits = $urandom_range(24, 1);
			end
			if (xfer_no == 8) begin
				kind = CMD_DATE_TIME;
				dir = 1'b0;
				cmd_bits = 8;
				data_bits = 130;
			end
			run_transfer(kind, dir, cmd_bits, data_bits);
			xfer_no++;
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// Drain: wait for every predicted result, then a few cycles more so
		// that any stray extra result would still be caught.
		while (sb.expected_pins.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		if (sb.failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
